// ----- hw/rtl/linear_blend_skinning_assert.svh -----
// assertion macros for the skinning block
`ifndef LINEAR_BLEND_SKINNING_ASSERT_SVH
`define LINEAR_BLEND_SKINNING_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define LBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define LBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/lbs_pkg.sv -----
// ----------------------------------------------------------------------------
// lbs_pkg
// types and constants shared by the skinning block
// ----------------------------------------------------------------------------
`default_nettype none
package lbs_pkg;

  localparam int BONE_COUNT = 256;
  localparam int ENTRIES = 12;
  localparam int MEM_DEPTH = BONE_COUNT * ENTRIES;
  localparam int MEM_AW = $clog2(MEM_DEPTH);
  localparam int ROW_AW = $clog2(BONE_COUNT * 3);
  localparam logic [15:0] WEIGHT_ONE = 16'd32768;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_APPLY = 2'd1,
    OP_PASS  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         bone;
    logic [3:0]         entry;
    logic signed [31:0] entry_value;
    logic [15:0]        weight;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               clipped;
  } out_item_t;

  // classified command between front and back
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_APPLY = 2'd1,
    CMD_PASS  = 2'd2,
    CMD_EMIT  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               valid_bone;
    logic               last;
    logic [MEM_AW-1:0]  addr;
    logic signed [31:0] value;
    logic [15:0]        weight;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } cmd_t;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63])
      return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/lbs_front.sv -----
// ----------------------------------------------------------------------------
// lbs_front
// classifies requests and queues commands for the back end
// ----------------------------------------------------------------------------
`default_nettype none
module lbs_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lbs_pkg::in_item_t in_item,
  input  wire logic             in_push,
  output logic                  in_full,
  output lbs_pkg::cmd_t         cmd,
  output logic                  cmd_valid,
  input  wire logic             cmd_take
);
  import lbs_pkg::*;

  cmd_t          q_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;
  cmd_t          c;
  logic          keep;
  logic          push_ok;

  assign in_full = (cnt_r == (QAW+1)'(QDEPTH));
  assign push_ok = in_push && !in_full;

  always_comb begin
    c = '0;
    c.value = in_item.entry_value;
    c.weight = (in_item.weight > WEIGHT_ONE) ? WEIGHT_ONE : in_item.weight;
    c.pos_x = in_item.pos_x;
    c.pos_y = in_item.pos_y;
    c.pos_z = in_item.pos_z;
    c.last = in_item.last;
    c.valid_bone = ({24'd0, in_item.bone} < 32'(BONE_COUNT));
    c.addr = MEM_AW'(({24'd0, in_item.bone} * 32'(ENTRIES)) + {28'd0, in_item.entry});
    keep = 1'b0;
    case (op_t'(in_item.op))
      OP_WRITE: begin
        c.kind = CMD_WRITE;
        keep = c.valid_bone && (in_item.entry < 4'(ENTRIES));
      end
      OP_APPLY: begin
        c.kind = CMD_APPLY;
        c.addr = MEM_AW'({24'd0, in_item.bone} * 32'(ENTRIES));
        keep = 1'b1;
      end
      OP_PASS: begin
        c.kind = CMD_PASS;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign cmd = q_r[rp_r];
  assign cmd_valid = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (push_ok && keep) q_r[wp_r] <= c;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push_ok && keep) wp_r <= wp_r + 1'b1;
      if (cmd_take) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push_ok && keep) - (QAW+1)'(cmd_take);
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/lbs_back.sv -----
// ----------------------------------------------------------------------------
// lbs_back
// matrix store, per-row multiply-accumulate sequencer and result register
// ----------------------------------------------------------------------------
`default_nettype none
module lbs_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire lbs_pkg::cmd_t  cmd,
  input  wire logic           cmd_valid,
  output logic                cmd_take,
  output lbs_pkg::out_item_t  out_item,
  output logic                out_empty,
  input  wire logic           out_pop
);
  import lbs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_P0, S_P1, S_P2, S_SUM, S_MUL, S_ACC, S_OUT
  } state_t;

  logic signed [31:0] mem [MEM_DEPTH];
  logic signed [31:0] rd_r;
  logic [MEM_AW-1:0]  ra_r;
  state_t             st_r;
  cmd_t               c_r;
  logic [1:0]         row_r;
  logic [1:0]         col_r;
  logic signed [49:0] t_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] acc_r [3];
  logic               full_r;
  out_item_t          res_r;
  logic signed [63:0] mp;
  logic signed [31:0] pv;
  logic signed [63:0] cur;
  logic               res_load;

  assign out_item = res_r;
  assign out_empty = !full_r;
  assign cmd_take = cmd_valid && (st_r == S_IDLE) &&
                    (cmd.kind == CMD_WRITE || !full_r || out_pop);
  // result register loads from a pass-through or a final influence
  assign res_load = (cmd_take && cmd.kind == CMD_PASS) ||
                    (st_r == S_OUT && c_r.last && (!full_r || out_pop));

  always_comb begin
    case (col_r)
      2'd0: pv = c_r.pos_x;
      2'd1: pv = c_r.pos_y;
      default: pv = c_r.pos_z;
    endcase
    mp = 64'(rd_r) * 64'(pv);
    cur = acc_r[row_r];
  end

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic clip32(logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd_take && cmd.kind == CMD_WRITE) mem[cmd.addr] <= cmd.value;
    rd_r <= mem[ra_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      full_r <= 1'b0;
      acc_r[0] <= '0;
      acc_r[1] <= '0;
      acc_r[2] <= '0;
      row_r <= '0;
      col_r <= '0;
      ra_r <= '0;
    end else begin
      if (res_load) full_r <= 1'b1;
      else if (out_pop && full_r) full_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (cmd_take) begin
            c_r <= cmd;
            row_r <= '0;
            col_r <= '0;
            ra_r <= cmd.addr;
            if (cmd.kind == CMD_PASS) begin
              res_r <= '{cmd.pos_x, cmd.pos_y, cmd.pos_z, 1'b0};
            end else if (cmd.kind == CMD_APPLY) begin
              st_r <= cmd.valid_bone ? S_RD : S_OUT;
            end
          end
        end
        S_RD: begin
          ra_r <= ra_r + 1'b1;
          t_r <= '0;
          st_r <= S_P0;
        end
        S_P0, S_P1, S_P2: begin
          // floor shift of the exact product
          t_r <= t_r + 50'(mp >>> 16);
          col_r <= col_r + 1'b1;
          ra_r <= ra_r + 1'b1;
          st_r <= (st_r == S_P0) ? S_P1 : (st_r == S_P1) ? S_P2 : S_SUM;
        end
        S_SUM: begin
          // offset column
          t_r <= t_r + 50'(rd_r);
          st_r <= S_MUL;
        end
        S_MUL: begin
          prod_r <= (64'(t_r) * 64'($signed({1'b0, c_r.weight}))) >>> 15;
          st_r <= S_ACC;
        end
        S_ACC: begin
          acc_r[row_r] <= sat_add64(cur, prod_r);
          col_r <= '0;
          if (row_r == 2'd2) begin
            st_r <= S_OUT;
          end else begin
            row_r <= row_r + 1'b1;
            st_r <= S_RD;
          end
        end
        S_OUT: begin
          if (c_r.last) begin
            if (!full_r || out_pop) begin
              res_r <= '{sat32(acc_r[0]), sat32(acc_r[1]), sat32(acc_r[2]),
                         clip32(acc_r[0]) | clip32(acc_r[1]) | clip32(acc_r[2])};
              acc_r[0] <= '0;
              acc_r[1] <= '0;
              acc_r[2] <= '0;
              st_r <= S_IDLE;
            end
          end else begin
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/linear_blend_skinning.sv -----
// ----------------------------------------------------------------------------
// linear_blend_skinning
// fixed-point skinning of vertex positions against a bone matrix table
// ----------------------------------------------------------------------------
// matrix writes and pass-through vertices are handled in the idle state of the back end
// an influence steps through idle, then per row four registered reads,
// an offset add, a weight multiply and a saturating accumulate, then a result step
// a pass-through loads the result register from the queue, a final influence at S_OUT
// reset (rst_n low, synchronous) empties the queue and clears accumulators;
// the matrix table is not cleared and is undefined until written
`default_nettype none
module linear_blend_skinning (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lbs_pkg::in_item_t  in_item,
  input  wire logic               in_push,
  output logic                    in_full,
  output lbs_pkg::out_item_t      out_item,
  output logic                    out_empty,
  input  wire logic               out_pop
);
  import lbs_pkg::*;

  // command queue between classifier and datapath
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;

  lbs_front u_front (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .in_push(in_push),
    .in_full(in_full), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
  );

  // back end owns the matrix memory, accumulators and result register
  lbs_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .cmd_valid(cmd_valid),
    .cmd_take(cmd_take), .out_item(out_item), .out_empty(out_empty),
    .out_pop(out_pop)
  );
endmodule
`default_nettype wire

// ----- hw/rtl/lbs_checker.sv -----
// ----------------------------------------------------------------------------
// lbs_checker
// port-level checks for the skinning block
// ----------------------------------------------------------------------------
`default_nettype none
`include "linear_blend_skinning_assert.svh"
module lbs_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire lbs_pkg::in_item_t  in_item,
  input wire logic               in_push,
  input wire logic               in_full,
  input wire lbs_pkg::out_item_t out_item,
  input wire logic               out_empty,
  input wire logic               out_pop
);
  `LBS_ASSERT_NEXT(a_held, clk, rst_n, !out_empty && !out_pop,
                   !out_empty && $stable(out_item))
  `LBS_ASSERT_NEXT(a_req_held, clk, rst_n, in_push && in_full,
                   in_push && $stable(in_item))
  `LBS_ASSERT_IMPL(a_ctrl_known, clk, rst_n, 1'b1, !$isunknown({in_full, out_empty}))
  `LBS_ASSERT_IMPL(a_clip_pos, clk, rst_n, !out_empty && out_item.clipped,
                   out_item.out_x == 32'sh7fffffff || out_item.out_x == 32'sh80000000 ||
                   out_item.out_y == 32'sh7fffffff || out_item.out_y == 32'sh80000000 ||
                   out_item.out_z == 32'sh7fffffff || out_item.out_z == 32'sh80000000)
endmodule

bind linear_blend_skinning lbs_checker u_chk (.*);
`default_nettype wire
